### rtl/eegr_pkg.sv
// Package for the GMST Earth-fixed/inertial rotation block.
// Shared constants, the word record and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package eegr_pkg;

    localparam int CORDIC_STEPS_DEF = 24;

    // Time base
    localparam logic [34:0] J2000_UNIX = 35'd946728000;
    localparam logic [34:0] HALF_DAY   = 35'd43200;

    // GMST polynomial, all in fractions of a turn
    localparam logic [31:0] GMST0_Q32 = 32'd3346025510;
    localparam logic [39:0] RATE_EXC  = 40'd584554549666;
    localparam logic [24:0] QUAD_COEF = 25'd18957209;
    localparam logic [21:0] CUBE_COEF = 22'd2585400;

    // Constant dividers by reciprocal multiply plus one correction.
    // A day is 128 * 675 seconds, a century is 128 * DIV_CENT seconds.
    localparam logic [9:0]  DIV_675  = 10'd675;
    localparam logic [24:0] DIV_CENT = 25'd24654375;
    localparam logic [28:0] R675_W   = 29'((64'd1 << 38) / 64'd675);
    localparam logic [26:0] R_CENT   = 27'((64'd1 << 51) / 64'd24654375);
    localparam logic [47:0] K57      = 48'((64'd1 << 57) / 64'd675);
    localparam logic [9:0]  M57      = 10'((64'd1 << 57) % 64'd675);
    localparam logic [16:0] R675_V   = 17'((64'd1 << 26) / 64'd675);

    // CORDIC start value: inverse gain in Q1.30
    localparam logic signed [33:0] CORDIC_KINV = 34'sd652032874;

    typedef struct packed {
        logic               req_type;
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic signed [47:0] z;
        logic [31:0]        angle;
    } t_item;

    // atan(2^-i) as a Q0.32 fraction of a turn
    function automatic logic [31:0] atan_turns(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/eegr_if.sv
// Valid/ready channel interfaces for the GMST rotation block.
// Depends on nothing; payload widths are fixed by the word format.
`default_nettype none

interface eegr_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [33:0]        unix_time;
    logic signed [47:0] x_in;
    logic signed [47:0] y_in;
    logic signed [47:0] z_in;

    modport source (output valid, req_type, unix_time, x_in, y_in, z_in, input ready);
    modport sink   (input valid, req_type, unix_time, x_in, y_in, z_in, output ready);
endinterface

interface eegr_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] x_out;
    logic signed [47:0] y_out;
    logic signed [47:0] z_out;
    logic [31:0]        sidereal_angle;

    modport source (output valid, x_out, y_out, z_out, sidereal_angle, input ready);
    modport sink   (input valid, x_out, y_out, z_out, sidereal_angle, output ready);
endinterface

`default_nettype wire

### rtl/eegr_gmst.sv
// Eight-stage pipeline for the GMST angle from a Unix time.
// Depends on eegr_pkg.
`default_nettype none

module eegr_gmst (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [33:0]    i_unix_time,
    input  eegr_pkg::t_item i_item,
    output logic           o_vld,
    output eegr_pkg::t_item o_item
);

    localparam int DEPTH = 8;

    logic [DEPTH-1:0] r_vld;
    eegr_pkg::t_item  r_item [DEPTH];

    // stage 1
    logic [34:0] n_u, n_dw;
    logic signed [34:0] n_d;
    logic n_neg;
    logic [33:0] n_m;
    logic [56:0] n_pw;
    logic [60:0] n_pm;
    logic signed [54:0] n_pdl, n_pdh;
    logic [6:0]  r_s1_low7;
    logic [27:0] r_s1_w;
    logic [56:0] r_s1_pw;
    logic        r_s1_neg;
    logic [33:0] r_s1_m;
    logic [60:0] r_s1_pm;
    logic signed [54:0] r_s1_pdl, r_s1_pdh;

    // stage 2
    logic [18:0] n_qw0;
    logic [27:0] n_tw, n_rwf;
    logic [26:0] n_qm;
    logic [51:0] n_tm, n_rmf;
    logic [63:0] n_p;
    logic [6:0]  r_s2_low7;
    logic [10:0] r_s2_rw;
    logic [26:0] r_s2_qm;
    logic [25:0] r_s2_rm;
    logic [63:0] r_s2_p;
    logic        r_s2_neg;

    // stage 3
    logic [10:0] n_rem;
    logic [16:0] r_s3_r;
    logic [26:0] r_s3_t24;
    logic [63:0] r_s3_p;
    logic        r_s3_neg;

    // stage 4
    logic [63:0] r_s4_rk;
    logic [25:0] r_s4_v;
    logic [53:0] r_s4_t2;
    logic [26:0] r_s4_t24;
    logic [63:0] r_s4_p;
    logic        r_s4_neg;

    // stage 5
    logic [42:0] n_qvp;
    logic [62:0] n_quadp;
    logic [56:0] n_cubep;
    logic [63:0] r_s5_rk;
    logic [25:0] r_s5_v;
    logic [16:0] r_s5_qv0;
    logic [18:0] r_s5_quad;
    logic [40:0] r_s5_cubep;
    logic [63:0] r_s5_p;
    logic        r_s5_neg;

    // stage 6
    logic [25:0] n_tv, n_rv;
    logic [62:0] n_cube;
    logic [63:0] r_s6_rk;
    logic [16:0] r_s6_qv;
    logic [18:0] r_s6_quad;
    logic [7:0]  r_s6_cube;
    logic [63:0] r_s6_p;
    logic        r_s6_neg;

    // stage 7
    logic [63:0] n_lin;
    logic [31:0] r_s7_lin;
    logic [18:0] r_s7_quad;
    logic [7:0]  r_s7_cube;
    logic        r_s7_neg;

    // stage 8
    logic [31:0] n_ang, r_ang;

    always_comb begin
        n_u   = {1'b0, i_unix_time} + eegr_pkg::HALF_DAY;
        n_neg = {1'b0, i_unix_time} < eegr_pkg::J2000_UNIX;
        n_d   = $signed({1'b0, i_unix_time} - eegr_pkg::J2000_UNIX);
        n_dw  = n_neg ? (eegr_pkg::J2000_UNIX - {1'b0, i_unix_time})
                      : ({1'b0, i_unix_time} - eegr_pkg::J2000_UNIX);
        n_m   = n_dw[33:0];
        n_pw  = {29'd0, n_u[34:7]} * {28'd0, eegr_pkg::R675_W};
        n_pm  = {27'd0, n_m} * {34'd0, eegr_pkg::R_CENT};
        n_pdl = $signed({{20{n_d[34]}}, n_d}) * $signed({35'd0, eegr_pkg::RATE_EXC[19:0]});
        n_pdh = $signed({{20{n_d[34]}}, n_d}) * $signed({35'd0, eegr_pkg::RATE_EXC[39:20]});
    end

    always_comb begin
        n_qw0 = r_s1_pw[56:38];
        n_tw  = {9'd0, n_qw0} * 28'd675;
        n_rwf = r_s1_w - n_tw;
        n_qm  = r_s1_pm[60:34];
        n_tm  = {25'd0, n_qm} * {27'd0, eegr_pkg::DIV_CENT};
        n_rmf = {1'b0, r_s1_m, 17'd0} - n_tm;
        n_p   = ({{9{r_s1_pdh[54]}}, r_s1_pdh} << 20) + {{9{r_s1_pdl[54]}}, r_s1_pdl};
    end

    always_comb begin
        n_rem = (r_s2_rw >= {1'b0, eegr_pkg::DIV_675}) ? r_s2_rw - {1'b0, eegr_pkg::DIV_675}
                                                        : r_s2_rw;
    end

    always_comb begin
        n_qvp   = {17'd0, r_s4_v} * {26'd0, eegr_pkg::R675_V};
        n_quadp = {25'd0, r_s4_t2[53:16]} * {38'd0, eegr_pkg::QUAD_COEF};
        n_cubep = {27'd0, r_s4_t2[53:24]} * {30'd0, r_s4_t24};
    end

    always_comb begin
        n_tv   = {9'd0, r_s5_qv0} * 26'd675;
        n_rv   = r_s5_v - n_tv;
        n_cube = {22'd0, r_s5_cubep} * {41'd0, eegr_pkg::CUBE_COEF};
    end

    always_comb begin
        n_lin = r_s6_rk + {47'd0, r_s6_qv} + r_s6_p;
        n_ang = r_s7_lin + eegr_pkg::GMST0_Q32 + {13'd0, r_s7_quad};
        // cubic term has the sign opposite to T
        n_ang = r_s7_neg ? n_ang + {24'd0, r_s7_cube} : n_ang - {24'd0, r_s7_cube};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= i_item;
            for (int k = 1; k < DEPTH; k++) begin
                r_item[k] <= r_item[k-1];
            end

            r_s1_low7 <= n_u[6:0];
            r_s1_w    <= n_u[34:7];
            r_s1_pw   <= n_pw;
            r_s1_neg  <= n_neg;
            r_s1_m    <= n_m;
            r_s1_pm   <= n_pm;
            r_s1_pdl  <= n_pdl;
            r_s1_pdh  <= n_pdh;

            r_s2_low7 <= r_s1_low7;
            r_s2_rw   <= n_rwf[10:0];
            r_s2_qm   <= n_qm;
            r_s2_rm   <= n_rmf[25:0];
            r_s2_p    <= n_p;
            r_s2_neg  <= r_s1_neg;

            r_s3_r    <= {n_rem[9:0], r_s2_low7};
            r_s3_t24  <= r_s2_qm + {26'd0, (r_s2_rm >= {1'b0, eegr_pkg::DIV_CENT})};
            r_s3_p    <= r_s2_p;
            r_s3_neg  <= r_s2_neg;

            r_s4_rk   <= {47'd0, r_s3_r} * {16'd0, eegr_pkg::K57};
            r_s4_v    <= {9'd0, r_s3_r} * {16'd0, eegr_pkg::M57};
            r_s4_t2   <= {27'd0, r_s3_t24} * {27'd0, r_s3_t24};
            r_s4_t24  <= r_s3_t24;
            r_s4_p    <= r_s3_p;
            r_s4_neg  <= r_s3_neg;

            r_s5_rk    <= r_s4_rk;
            r_s5_v     <= r_s4_v;
            r_s5_qv0   <= n_qvp[42:26];
            r_s5_quad  <= n_quadp[62:44];
            r_s5_cubep <= n_cubep[56:16];
            r_s5_p     <= r_s4_p;
            r_s5_neg   <= r_s4_neg;

            r_s6_rk   <= r_s5_rk;
            r_s6_qv   <= r_s5_qv0 + {16'd0, (n_rv >= 26'd675)};
            r_s6_quad <= r_s5_quad;
            r_s6_cube <= n_cube[62:55];
            r_s6_p    <= r_s5_p;
            r_s6_neg  <= r_s5_neg;

            r_s7_lin  <= n_lin[63:32];
            r_s7_quad <= r_s6_quad;
            r_s7_cube <= r_s6_cube;
            r_s7_neg  <= r_s6_neg;

            r_ang     <= n_ang;
        end
    end

    always_comb begin
        o_item       = r_item[DEPTH-1];
        o_item.angle = r_ang;
    end
    assign o_vld = r_vld[DEPTH-1];

    // reciprocal estimates are never more than one below the true quotient
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_s2_rw < 11'd1350) && (r_s2_rm < {eegr_pkg::DIV_CENT, 1'b0}))
        else $error("gmst: remainder out of range after reciprocal divide");

    a_day_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_s3_r < 17'd86400))
        else $error("gmst: seconds of day out of range");

endmodule

`default_nettype wire

### rtl/eegr_cordic.sv
// Pipelined CORDIC: quadrant split, one rotation per stage, quadrant fold.
// Depends on eegr_pkg.
`default_nettype none

module eegr_cordic #(
    parameter int CORDIC_STEPS = eegr_pkg::CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  eegr_pkg::t_item   i_item,
    output logic              o_vld,
    output eegr_pkg::t_item   o_item,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);

    localparam int NIT = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

    logic [NIT+1:0]     r_vld;
    logic signed [33:0] r_cx [NIT+1];
    logic signed [33:0] r_cy [NIT+1];
    logic signed [32:0] r_z  [NIT+1];
    logic [1:0]         r_q  [NIT+1];
    eegr_pkg::t_item    r_item [NIT+1];

    logic [31:0] n_th, n_qs, n_ru;
    logic [1:0]  n_q;
    logic signed [33:0] r_cos, r_sin;
    eegr_pkg::t_item r_oitem;

    always_comb begin
        n_th = i_item.req_type ? (32'd0 - i_item.angle) : i_item.angle;
        n_qs = n_th + 32'h2000_0000;
        n_q  = n_qs[31:30];
        n_ru = n_th - {n_q, 30'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NIT:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0]   <= eegr_pkg::CORDIC_KINV;
            r_cy[0]   <= '0;
            r_z[0]    <= {n_ru[31], n_ru};
            r_q[0]    <= n_q;
            r_item[0] <= i_item;
        end
    end

    for (genvar i = 0; i < NIT; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][32]) begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_z[i+1]  <= r_z[i] - $signed({1'b0, eegr_pkg::atan_turns(i)});
                end else begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_z[i+1]  <= r_z[i] + $signed({1'b0, eegr_pkg::atan_turns(i)});
                end
                r_q[i+1]    <= r_q[i];
                r_item[i+1] <= r_item[i];
            end
        end
    end

    // fold the quarter turn back in exactly
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[NIT])
                2'd0: begin
                    r_cos <= r_cx[NIT];
                    r_sin <= r_cy[NIT];
                end
                2'd1: begin
                    r_cos <= -r_cy[NIT];
                    r_sin <= r_cx[NIT];
                end
                2'd2: begin
                    r_cos <= -r_cx[NIT];
                    r_sin <= -r_cy[NIT];
                end
                default: begin
                    r_cos <= r_cy[NIT];
                    r_sin <= -r_cx[NIT];
                end
            endcase
            r_oitem <= r_item[NIT];
        end
    end

    assign o_vld  = r_vld[NIT+1];
    assign o_item = r_oitem;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

    a_resid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_z[0] >= -33'sd536870912) && (r_z[0] < 33'sd536870912))
        else $error("cordic: residual angle outside one eighth turn");

endmodule

`default_nettype wire

### rtl/eegr_rotate.sv
// Four-stage rotation: magnitudes, split products, rounding, sum and clamp.
// Depends on eegr_pkg.
`default_nettype none

module eegr_rotate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  eegr_pkg::t_item    i_item,
    input  logic signed [33:0] i_cos,
    input  logic signed [33:0] i_sin,
    output logic               o_vld,
    output eegr_pkg::t_item    o_item,
    output logic signed [47:0] o_x,
    output logic signed [47:0] o_y
);

    localparam int DEPTH = 4;

    logic [DEPTH-1:0] r_vld;
    eegr_pkg::t_item  r_item [DEPTH];

    logic [47:0] r_r0_m [2];   // |x|, |y|
    logic [32:0] r_r0_k [2];   // |cos|, |sin|
    logic        r_r0_sm [2];
    logic        r_r0_sk [2];

    // lanes: x*cos, y*sin, x*sin, y*cos
    logic [56:0] r_r1_hi [4];
    logic [56:0] r_r1_lo [4];
    logic        r_r1_neg [4];
    logic signed [51:0] r_r2_p [4];
    logic signed [47:0] r_x, r_y;

    logic [47:0] n_mx, n_my;
    logic [33:0] n_kc, n_ks;
    logic [56:0] n_hi [4];
    logic [56:0] n_lo [4];
    logic        n_neg [4];
    logic [1:0]  n_lane;
    logic [80:0] n_sum [4];
    logic signed [51:0] n_p [4];
    logic signed [52:0] n_xo, n_yo;

    function automatic logic signed [47:0] sat48(input logic signed [52:0] v);
        logic signed [47:0] r;
        if (v > 53'sd140737488355327) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (v < -53'sd140737488355328) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    always_comb begin
        n_mx = i_item.x[47] ? 48'd0 - i_item.x : i_item.x;
        n_my = i_item.y[47] ? 48'd0 - i_item.y : i_item.y;
        n_kc = i_cos[33] ? 34'd0 - i_cos : i_cos;
        n_ks = i_sin[33] ? 34'd0 - i_sin : i_sin;
    end

    always_comb begin
        n_lane = '0;
        for (int l = 0; l < 4; l++) begin
            n_lane  = 2'(l);
            n_hi[l] = {33'd0, r_r0_m[n_lane[0]][47:24]} * {24'd0, r_r0_k[n_lane[0] ^ n_lane[1]]};
            n_lo[l] = {33'd0, r_r0_m[n_lane[0]][23:0]} * {24'd0, r_r0_k[n_lane[0] ^ n_lane[1]]};
            n_neg[l] = r_r0_sm[n_lane[0]] ^ r_r0_sk[n_lane[0] ^ n_lane[1]];
        end
    end

    // round half away from zero: magnitude plus one half, then sign
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            n_sum[l] = {r_r1_hi[l], 24'd0} + {24'd0, r_r1_lo[l]} + 81'd536870912;
            n_p[l]   = r_r1_neg[l] ? -$signed({1'b0, n_sum[l][80:30]})
                                   : $signed({1'b0, n_sum[l][80:30]});
        end
    end

    always_comb begin
        n_xo = {r_r2_p[0][51], r_r2_p[0]} - {r_r2_p[1][51], r_r2_p[1]};
        n_yo = {r_r2_p[2][51], r_r2_p[2]} + {r_r2_p[3][51], r_r2_p[3]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= i_item;
            for (int k = 1; k < DEPTH; k++) begin
                r_item[k] <= r_item[k-1];
            end
            r_r0_m[0]  <= n_mx;
            r_r0_m[1]  <= n_my;
            r_r0_k[0]  <= n_kc[32:0];
            r_r0_k[1]  <= n_ks[32:0];
            r_r0_sm[0] <= i_item.x[47];
            r_r0_sm[1] <= i_item.y[47];
            r_r0_sk[0] <= i_cos[33];
            r_r0_sk[1] <= i_sin[33];
            for (int l = 0; l < 4; l++) begin
                r_r1_hi[l]  <= n_hi[l];
                r_r1_lo[l]  <= n_lo[l];
                r_r1_neg[l] <= n_neg[l];
                r_r2_p[l]   <= n_p[l];
            end
            r_x <= sat48(n_xo);
            r_y <= sat48(n_yo);
        end
    end

    assign o_vld  = r_vld[DEPTH-1];
    assign o_item = r_item[DEPTH-1];
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

`default_nettype wire

### rtl/ecef_eci_gmst_rotation.sv
// Top level: GMST angle, CORDIC sine/cosine and Z-axis rotation of a point.
// Depends on eegr_pkg, eegr_if, eegr_gmst, eegr_cordic, eegr_rotate.
//
//  port    dir  word                                         handshake
//  i_in    in   req_type, unix_time, x_in, y_in, z_in        valid/ready
//  o_out   out  x_out, y_out, z_out, sidereal_angle          valid/ready
//
// One word per cycle sustained while o_out is ready. The GMST polynomial,
// the CORDIC and the rotator follow one another in that order;
// the CORDIC stage chain sets the depth.
// Reset clears only the valid bits; payload registers are not reset.
// A stall on o_out freezes every stage together; the last stage is the
// output register, and i_in.ready drops only while it holds an untaken word.
`default_nettype none

module ecef_eci_gmst_rotation #(
    parameter int CORDIC_STEPS = eegr_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eegr_in_if.sink     i_in,
    eegr_out_if.source  o_out
);

    logic w_en;

    eegr_pkg::t_item w_in_item;
    logic            w_g_vld;
    eegr_pkg::t_item w_g_item;
    logic            w_c_vld;
    eegr_pkg::t_item w_c_item;
    logic signed [33:0] w_cos, w_sin;
    logic            w_r_vld;
    eegr_pkg::t_item w_r_item;
    logic signed [47:0] w_x, w_y;

    // whole pipeline advances unless the output word is held
    assign w_en       = !w_r_vld || o_out.ready;
    assign i_in.ready = w_en;

    always_comb begin
        w_in_item.req_type = i_in.req_type;
        w_in_item.x        = i_in.x_in;
        w_in_item.y        = i_in.y_in;
        w_in_item.z        = i_in.z_in;
        w_in_item.angle    = '0;    // filled by the GMST pipeline
    end

    eegr_gmst u_gmst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_vld       (i_in.valid),
        .i_unix_time (i_in.unix_time),
        .i_item      (w_in_item),
        .o_vld       (w_g_vld),
        .o_item      (w_g_item)
    );

    eegr_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_g_vld),
        .i_item  (w_g_item),
        .o_vld   (w_c_vld),
        .o_item  (w_c_item),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    eegr_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_c_vld),
        .i_item  (w_c_item),
        .i_cos   (w_cos),
        .i_sin   (w_sin),
        .o_vld   (w_r_vld),
        .o_item  (w_r_item),
        .o_x     (w_x),
        .o_y     (w_y)
    );

    assign o_out.valid          = w_r_vld;
    assign o_out.x_out          = w_x;
    assign o_out.y_out          = w_y;
    assign o_out.z_out          = w_r_item.z;
    assign o_out.sidereal_angle = w_r_item.angle;

    // a held output word must block new input
    a_hold_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("top: input accepted while output word held");

endmodule

`default_nettype wire
